### rtl/euler_rpy_to_pose_matrix_macros.svh
// Assertion macros for the pose matrix RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef EULER_RPY_TO_POSE_MATRIX_MACROS_SVH
`define EULER_RPY_TO_POSE_MATRIX_MACROS_SVH

// Plain property, checked at every rising clock edge out of reset.
`define ERPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("erpm check failed");

// Implication: when cond holds, prop must hold in the same cycle.
`define ERPM_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("erpm check failed");

`endif

### rtl/erpm_pkg.sv
// Package for the ZYX Euler angle to pose matrix block.
// Holds sizes, the CORDIC arctangent table, the cell payload type and helpers.
package erpm_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int COEFF_FRAC_BITS = 14;
  localparam int CORDIC_STEPS    = 16;

  localparam int IN_ANGLE_W = 16;
  localparam int POS_W      = 32;
  localparam int COEFF_W    = 16;
  localparam int WORK_FRAC  = 30;
  localparam int XY_W       = 34;
  localparam int Z_W        = 33;
  localparam int TRIG_W     = 32;
  localparam int PROD_W     = 2 * TRIG_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int STEP_W     = 5;
  localparam int Q_SHIFT    = 2 * WORK_FRAC - COEFF_FRAC_BITS;
  localparam int Q_W        = SUM_W - Q_SHIFT;

  localparam logic signed [XY_W-1:0] START_GAIN = XY_W'(652032874);

  typedef struct packed {
    logic                      valid;
    logic [2:0][XY_W-1:0]      x;
    logic [2:0][XY_W-1:0]      y;
    logic [2:0][Z_W-1:0]       z;
    logic [2:0]                flip;
    logic [2:0][POS_W-1:0]     pos;
  } cordic_t;

  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] s);
    logic [31:0] a;
    unique case (s)
      5'd0:  a = 32'h20000000;  5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;  5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;  5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;  5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;  5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;  5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;  5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;  5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;  5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;  5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;  5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;  5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;  5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;  5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;  5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;  5'd31: a = 32'h00000000;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // Round a Q.60 entry to the coefficient format and clamp to +-1.0.
  function automatic logic [COEFF_W-1:0] quantize(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    logic signed [Q_W-1:0]   r;
    logic signed [Q_W-1:0]   lim;
    t   = v + (SUM_W'(1) <<< (Q_SHIFT - 1));
    r   = Q_W'(t >>> Q_SHIFT);
    lim = Q_W'(1) <<< COEFF_FRAC_BITS;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return COEFF_W'(r);
  endfunction

endpackage

### rtl/erpm_if.sv
// Valid/ready channel interfaces for pose requests and matrix results.
// Depends on erpm_pkg for field widths.
interface erpm_pose_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [erpm_pkg::IN_ANGLE_W-1:0] roll_angle;
  logic signed [erpm_pkg::IN_ANGLE_W-1:0] pitch_angle;
  logic signed [erpm_pkg::IN_ANGLE_W-1:0] yaw_angle;
  logic signed [erpm_pkg::POS_W-1:0]      pos_x;
  logic signed [erpm_pkg::POS_W-1:0]      pos_y;
  logic signed [erpm_pkg::POS_W-1:0]      pos_z;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface erpm_mat_if;
  logic                                valid;
  logic                                ready;
  logic signed [erpm_pkg::COEFF_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [erpm_pkg::POS_W-1:0]   t_x, t_y, t_z;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, t_x, t_y, t_z,
                  input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, t_x, t_y, t_z,
                output ready);
endinterface

### rtl/erpm_cordic_cell.sv
// One CORDIC rotation step for all three angles, registered.
// Depends on erpm_pkg (cordic_t, atan_turn).
module erpm_cordic_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [erpm_pkg::STEP_W-1:0]   step_i,
  input  erpm_pkg::cordic_t             cell_i,
  output erpm_pkg::cordic_t             cell_o
);

  erpm_pkg::cordic_t cell_d, cell_q;
  logic              valid_q;
  logic signed [erpm_pkg::Z_W-1:0] atan_z;

  assign atan_z = erpm_pkg::Z_W'(erpm_pkg::atan_turn(step_i));

  always_comb begin
    cell_d = cell_i;
    for (int k = 0; k < 3; k++) begin
      logic signed [erpm_pkg::XY_W-1:0] xv, yv, dx, dy;
      logic signed [erpm_pkg::Z_W-1:0]  zv;
      xv = $signed(cell_i.x[k]);
      yv = $signed(cell_i.y[k]);
      zv = $signed(cell_i.z[k]);
      dx = yv >>> step_i;
      dy = xv >>> step_i;
      if (!zv[erpm_pkg::Z_W-1]) begin
        cell_d.x[k] = xv - dx;
        cell_d.y[k] = yv + dy;
        cell_d.z[k] = zv - atan_z;
      end else begin
        cell_d.x[k] = xv + dx;
        cell_d.y[k] = yv - dy;
        cell_d.z[k] = zv + atan_z;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  // take the valid flag from its reset register
  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

### rtl/erpm_matrix.sv
// Sign fix, products and sums that turn sines and cosines into the matrix.
// Depends on erpm_pkg (cordic_t, quantize, widths).
module erpm_matrix (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  erpm_pkg::cordic_t                     cell_i,
  output logic                                  valid_o,
  output logic [8:0][erpm_pkg::COEFF_W-1:0]     coeff_o,
  output logic [2:0][erpm_pkg::POS_W-1:0]       pos_o
);

  localparam int TW = erpm_pkg::TRIG_W;
  localparam int PW = erpm_pkg::PROD_W;
  localparam int SW = erpm_pkg::SUM_W;

  // stage A: sines and cosines, index 0 roll, 1 pitch, 2 yaw
  logic                     a_valid_q;
  logic signed [TW-1:0]     s_q [3];
  logic signed [TW-1:0]     c_q [3];
  logic [2:0][erpm_pkg::POS_W-1:0] a_pos_q;

  // stage B: first products
  logic                     b_valid_q;
  logic signed [PW-1:0]     b_spsr_q, b_spcr_q, b_cycp_q, b_sycp_q, b_cpsr_q, b_cpcr_q;
  logic signed [TW-1:0]     b_sy_q, b_cy_q, b_sr_q, b_cr_q, b_sp_q;
  logic [2:0][erpm_pkg::POS_W-1:0] b_pos_q;

  // stage C: second products
  logic                     c_valid_q;
  logic signed [PW-1:0]     c_p_q [8];
  logic signed [PW-1:0]     c_cycp_q, c_sycp_q, c_cpsr_q, c_cpcr_q;
  logic signed [TW-1:0]     c_sp_q;
  logic [2:0][erpm_pkg::POS_W-1:0] c_pos_q;

  // stage D: output
  logic                     d_valid_q;
  logic [8:0][erpm_pkg::COEFF_W-1:0] d_coeff_q;
  logic [2:0][erpm_pkg::POS_W-1:0]   d_pos_q;

  logic signed [PW-1:0] sp_sr_t, sp_cr_t;
  logic signed [TW-1:0] sp_sr, sp_cr;
  logic signed [SW-1:0] sum [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= cell_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  // round the two pitch-roll products back to Q.30
  always_comb begin
    sp_sr_t = b_spsr_q + (PW'(1) <<< (erpm_pkg::WORK_FRAC - 1));
    sp_cr_t = b_spcr_q + (PW'(1) <<< (erpm_pkg::WORK_FRAC - 1));
    sp_sr   = TW'(sp_sr_t >>> erpm_pkg::WORK_FRAC);
    sp_cr   = TW'(sp_cr_t >>> erpm_pkg::WORK_FRAC);
  end

  always_comb begin
    sum[0] = SW'(c_cycp_q);
    sum[1] = SW'(c_p_q[0]) - SW'(c_p_q[1]);
    sum[2] = SW'(c_p_q[2]) + SW'(c_p_q[3]);
    sum[3] = SW'(c_sycp_q);
    sum[4] = SW'(c_p_q[4]) + SW'(c_p_q[5]);
    sum[5] = SW'(c_p_q[6]) - SW'(c_p_q[7]);
    sum[6] = -(SW'(c_sp_q) <<< erpm_pkg::WORK_FRAC);
    sum[7] = SW'(c_cpsr_q);
    sum[8] = SW'(c_cpcr_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [erpm_pkg::XY_W-1:0] xv, yv;
        xv = $signed(cell_i.x[k]);
        yv = $signed(cell_i.y[k]);
        // undo the half-turn fold
        c_q[k] <= TW'(cell_i.flip[k] ? -xv : xv);
        s_q[k] <= TW'(cell_i.flip[k] ? -yv : yv);
      end
      a_pos_q <= cell_i.pos;

      b_spsr_q <= s_q[1] * s_q[0];
      b_spcr_q <= s_q[1] * c_q[0];
      b_cycp_q <= c_q[2] * c_q[1];
      b_sycp_q <= s_q[2] * c_q[1];
      b_cpsr_q <= c_q[1] * s_q[0];
      b_cpcr_q <= c_q[1] * c_q[0];
      b_sy_q   <= s_q[2];
      b_cy_q   <= c_q[2];
      b_sr_q   <= s_q[0];
      b_cr_q   <= c_q[0];
      b_sp_q   <= s_q[1];
      b_pos_q  <= a_pos_q;

      c_p_q[0] <= b_cy_q * sp_sr;
      c_p_q[1] <= b_sy_q * b_cr_q;
      c_p_q[2] <= b_cy_q * sp_cr;
      c_p_q[3] <= b_sy_q * b_sr_q;
      c_p_q[4] <= b_sy_q * sp_sr;
      c_p_q[5] <= b_cy_q * b_cr_q;
      c_p_q[6] <= b_sy_q * sp_cr;
      c_p_q[7] <= b_cy_q * b_sr_q;
      c_cycp_q <= b_cycp_q;
      c_sycp_q <= b_sycp_q;
      c_cpsr_q <= b_cpsr_q;
      c_cpcr_q <= b_cpcr_q;
      c_sp_q   <= b_sp_q;
      c_pos_q  <= b_pos_q;

      for (int k = 0; k < 9; k++) begin
        d_coeff_q[k] <= erpm_pkg::quantize(sum[k]);
      end
      d_pos_q <= c_pos_q;
    end
  end

  assign valid_o = d_valid_q;
  assign coeff_o = d_coeff_q;
  assign pos_o   = d_pos_q;

endmodule

### rtl/euler_rpy_to_pose_matrix.sv
// ZYX Euler angles to pose matrix, registered from request to result
// (16 CORDIC cells, then sign fix, two product stages and a sum stage).
// Throughput one request per cycle; the whole pipeline holds while a result
// waits and the sink is not ready.
// Reset clears all valid flags; data registers are not reset.
`include "euler_rpy_to_pose_matrix_macros.svh"
module euler_rpy_to_pose_matrix (
  input  logic        clk_i,
  input  logic        rst_ni,
  erpm_pose_if.sink   pose_i,
  erpm_mat_if.source  mat_o
);

  localparam int N = erpm_pkg::CORDIC_STEPS;

  erpm_pkg::cordic_t chain [N+1];
  logic                                  en;
  logic                                  out_valid;
  logic [8:0][erpm_pkg::COEFF_W-1:0]     coeff;
  logic [2:0][erpm_pkg::POS_W-1:0]       pos;
  logic [2:0][erpm_pkg::IN_ANGLE_W-1:0]  ang;

  // advance when the output slot is free or being drained
  assign en           = !out_valid || mat_o.ready;
  assign pose_i.ready = en;

  assign ang = {pose_i.yaw_angle, pose_i.pitch_angle, pose_i.roll_angle};

  // fold each angle into [-pi/2, pi/2) as a 32-bit turn
  always_comb begin
    chain[0].valid = pose_i.valid;
    chain[0].pos   = {pose_i.pos_z, pose_i.pos_y, pose_i.pos_x};
    for (int k = 0; k < 3; k++) begin
      logic [31:0] ua, up;
      ua = 32'(ang[k][erpm_pkg::ANGLE_BITS-1:0]) << (32 - erpm_pkg::ANGLE_BITS);
      up = ua + 32'h4000_0000;
      chain[0].flip[k] = up[31];
      ua[31] = ua[31] ^ up[31];
      chain[0].x[k] = erpm_pkg::START_GAIN;
      chain[0].y[k] = '0;
      chain[0].z[k] = erpm_pkg::Z_W'($signed(ua));
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    erpm_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (erpm_pkg::STEP_W'(g)),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  erpm_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cell_i  (chain[N]),
    .valid_o (out_valid),
    .coeff_o (coeff),
    .pos_o   (pos)
  );

  assign mat_o.valid = out_valid;
  assign mat_o.r00   = coeff[0];
  assign mat_o.r01   = coeff[1];
  assign mat_o.r02   = coeff[2];
  assign mat_o.r10   = coeff[3];
  assign mat_o.r11   = coeff[4];
  assign mat_o.r12   = coeff[5];
  assign mat_o.r20   = coeff[6];
  assign mat_o.r21   = coeff[7];
  assign mat_o.r22   = coeff[8];
  assign mat_o.t_x   = pos[0];
  assign mat_o.t_y   = pos[1];
  assign mat_o.t_z   = pos[2];

  `ERPM_ASSERT(a_ready_tracks_out, pose_i.ready == (!out_valid || mat_o.ready))
  `ERPM_ASSERT_IMP(a_r20_range, out_valid, mat_o.r20 <= 16384 && mat_o.r20 >= -16384)
  `ERPM_ASSERT_IMP(a_r00_range, out_valid, mat_o.r00 <= 16384 && mat_o.r00 >= -16384)
  `ERPM_ASSERT_IMP(a_stall_holds, out_valid && !mat_o.ready, ##1 (out_valid && $stable(coeff)))

endmodule

### sim/tb_pose_scoreboard.sv
// Scoreboard for the pose matrix block: predicts each matrix from a request.
// Depends on erpm_pkg for widths; holds its own CORDIC and rounding model.
`timescale 1ns / 100ps

package tb_pose_sb_pkg;

  typedef struct packed {
    logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [31:0] t_x, t_y, t_z;
  } pose_mat_t;

  class pose_scoreboard;
    pose_mat_t pending[$];
    int        n_err;

    function new();
      n_err = 0;
    endfunction

    static function longint atan_step(int s);
      longint tab[32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
        64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
        64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
      return tab[s];
    endfunction

    // Sine and cosine in Q.30 from a binary angle.
    static function void trig(input logic [15:0] ang, output longint sn, output longint cs);
      logic [31:0] turn;
      logic        flip;
      longint      x, y, z, dx, dy;
      turn = {ang[erpm_pkg::ANGLE_BITS-1:0], {(32-erpm_pkg::ANGLE_BITS){1'b0}}};
      flip = ((turn + 32'h40000000) >> 31) != 0;
      if (flip) turn = turn ^ 32'h80000000;
      x = 652032874;
      y = 0;
      z = longint'($signed(turn));
      for (int i = 0; i < erpm_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> (i & 31);
        dy = x >>> (i & 31);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_step(i & 31);
        end else begin
          x += dx; y -= dy; z += atan_step(i & 31);
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      sn = y;
      cs = x;
    endfunction

    static function logic signed [15:0] to_coeff(longint v);
      int     sh;
      longint r, lim;
      sh  = 60 - erpm_pkg::COEFF_FRAC_BITS;
      lim = longint'(1) << erpm_pkg::COEFF_FRAC_BITS;
      r   = (v + (longint'(1) << (sh - 1))) >>> sh;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
    endfunction

    function void note_request(logic [15:0] ro, pi, ya, logic [31:0] px, py, pz);
      longint sr, cr, sp, cp, sy, cy, spsr, spcr;
      pose_mat_t m;
      trig(ro, sr, cr);
      trig(pi, sp, cp);
      trig(ya, sy, cy);
      spsr = (sp * sr + (longint'(1) << 29)) >>> 30;
      spcr = (sp * cr + (longint'(1) << 29)) >>> 30;
      m.r00 = to_coeff(cy * cp);
      m.r01 = to_coeff(cy * spsr - sy * cr);
      m.r02 = to_coeff(cy * spcr + sy * sr);
      m.r10 = to_coeff(sy * cp);
      m.r11 = to_coeff(sy * spsr + cy * cr);
      m.r12 = to_coeff(sy * spcr - cy * sr);
      m.r20 = to_coeff(-sp * (longint'(1) << 30));
      m.r21 = to_coeff(cp * sr);
      m.r22 = to_coeff(cp * cr);
      m.t_x = px;
      m.t_y = py;
      m.t_z = pz;
      pending.push_back(m);
    endfunction

    function void cmp(string nm, longint e, longint a);
      if (e != a) begin
        $error("%s expected %0d actual %0d", nm, e, a);
        n_err++;
      end
    endfunction

    function void check_matrix(pose_mat_t a);
      pose_mat_t e;
      if (pending.size() == 0) begin
        $error("matrix result with no request outstanding");
        n_err++;
        return;
      end
      e = pending.pop_front();
      cmp("r00", e.r00, a.r00); cmp("r01", e.r01, a.r01); cmp("r02", e.r02, a.r02);
      cmp("r10", e.r10, a.r10); cmp("r11", e.r11, a.r11); cmp("r12", e.r12, a.r12);
      cmp("r20", e.r20, a.r20); cmp("r21", e.r21, a.r21); cmp("r22", e.r22, a.r22);
      cmp("t_x", e.t_x, a.t_x); cmp("t_y", e.t_y, a.t_y); cmp("t_z", e.t_z, a.t_z);
    endfunction
  endclass
endpackage

### sim/tb.sv
// Top of the pose matrix testbench: drives requests, stalls results, checks.
// Depends on erpm_pkg, erpm_if, the block and tb_pose_sb_pkg.
`timescale 1ns / 100ps

module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle = 0;
  bit   calm = 1'b0;

  erpm_pose_if pose_if ();
  erpm_mat_if  mat_if ();

  euler_rpy_to_pose_matrix dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pose_i (pose_if.sink),
    .mat_o  (mat_if.source)
  );

  tb_pose_sb_pkg::pose_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  initial begin
    pose_if.valid = 1'b0;
    pose_if.roll_angle = '0;
    pose_if.pitch_angle = '0;
    pose_if.yaw_angle = '0;
    pose_if.pos_x = '0;
    pose_if.pos_y = '0;
    pose_if.pos_z = '0;
    mat_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sample results and note requests at the rising edge.
  always @(posedge clk_i) begin
    tb_pose_sb_pkg::pose_mat_t a;
    if (rst_ni && mat_if.valid && mat_if.ready) begin
      a = '{mat_if.r00, mat_if.r01, mat_if.r02, mat_if.r10, mat_if.r11, mat_if.r12,
            mat_if.r20, mat_if.r21, mat_if.r22, mat_if.t_x, mat_if.t_y, mat_if.t_z};
      sb.check_matrix(a);
    end
    if (rst_ni && pose_if.valid && pose_if.ready)
      sb.note_request(pose_if.roll_angle, pose_if.pitch_angle, pose_if.yaw_angle,
                      pose_if.pos_x, pose_if.pos_y, pose_if.pos_z);
  end

  // Result side stalls at random, except in the calm stretch.
  always @(negedge clk_i) begin
    if (!rst_ni) mat_if.ready <= 1'b0;
    else mat_if.ready <= calm || ($urandom_range(99) >= 16);
  end

  task automatic send_pose(logic [15:0] ro, pi, ya, logic [31:0] px, py, pz);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 16) begin
      pose_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pose_if.valid <= 1'b1;
    pose_if.roll_angle <= ro;
    pose_if.pitch_angle <= pi;
    pose_if.yaw_angle <= ya;
    pose_if.pos_x <= px;
    pose_if.pos_y <= py;
    pose_if.pos_z <= pz;
    @(posedge clk_i);
    while (!pose_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_angle();
    logic [15:0] e[10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
                           16'h8001, 16'h3FFF, 16'h4001, 16'hBFFF, 16'hFFFF};
    if ($urandom_range(9) == 0) return e[$urandom_range(9)];
    return 16'($urandom());
  endfunction

  initial begin
    logic [15:0] dirs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                             16'h7FFF, 16'h8001, 16'h3FFF, 16'h2000};
    int wait_n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Directed: quadrant boundaries, near one, position extremes.
    for (int i = 0; i < 8; i++)
      send_pose(dirs[i], dirs[(i + 3) % 8], dirs[(i + 5) % 8],
                32'h7FFFFFFF, 32'h80000000, i[31:0]);
    send_pose(16'h4000, 16'h4000, 16'h4000, 32'h0, 32'hFFFFFFFF, 32'h80000000);
    send_pose(16'hC000, 16'hC000, 16'hC000, 32'hFFFFFFFF, 32'h0, 32'h7FFFFFFF);
    send_pose(16'hFFFF, 16'h0001, 16'h8000, 32'h55555555, 32'hAAAAAAAA, 32'h1);
    for (int i = 0; i < 450; i++) begin
      calm = (i >= 200 && i < 280);
      send_pose(pick_angle(), pick_angle(), pick_angle(),
                $urandom(), $urandom(), $urandom());
    end
    calm = 1'b0;
    @(negedge clk_i);
    pose_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    wait_n = 0;
    while (wait_n < 40) begin
      @(posedge clk_i);
      wait_n++;
    end
    if (sb.n_err == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### euler_rpy_to_pose_matrix.f
+incdir+rtl
rtl/erpm_pkg.sv
rtl/erpm_if.sv
rtl/erpm_cordic_cell.sv
rtl/erpm_matrix.sv
rtl/euler_rpy_to_pose_matrix.sv
sim/tb_pose_scoreboard.sv
sim/tb.sv
